// File: hdl/tia_pkg.sv
// Types, operation codes and width helpers for the typed integer ALU.
`default_nettype none
package tia_pkg;

    localparam int DIV_STEPS = 64;
    localparam int LAST_STAGE = DIV_STEPS + 2;

    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,
        OP_SUB  = 5'd1,
        OP_MUL  = 5'd2,
        OP_DIV  = 5'd3,
        OP_MOD  = 5'd4,
        OP_AND  = 5'd5,
        OP_OR   = 5'd6,
        OP_XOR  = 5'd7,
        OP_SHL  = 5'd8,
        OP_SHR  = 5'd9,
        OP_EQ   = 5'd10,
        OP_NE   = 5'd11,
        OP_LT   = 5'd12,
        OP_LE   = 5'd13,
        OP_GT   = 5'd14,
        OP_GE   = 5'd15,
        OP_CAST = 5'd16
    } op_t;

    typedef enum logic [1:0] {
        W8  = 2'd0,
        W16 = 2'd1,
        W32 = 2'd2,
        W64 = 2'd3
    } wsel_t;

    typedef struct packed {
        logic [4:0]  mode;
        logic [1:0]  wsel;
        logic        uns;
        logic [1:0]  twsel;
        logic        tuns;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] sa;
        logic [63:0] sb;
    } front_t;

    typedef struct packed {
        logic [4:0]  mode;
        logic [1:0]  wsel;
        logic        uns;
        logic [63:0] val;
        logic [63:0] p0;
        logic [31:0] p1;
        logic [31:0] p2;
        logic        neg_q;
        logic        neg_r;
        logic        dz;
        logic [63:0] dvs;
        logic [63:0] qr;
        logic [63:0] rem;
    } pipe_t;

    function automatic logic [63:0] width_mask(logic [1:0] sel);
        logic [63:0] m;
        case (sel)
            W8:      m = 64'h0000_0000_0000_00FF;
            W16:     m = 64'h0000_0000_0000_FFFF;
            W32:     m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [63:0] fit(logic [63:0] v, logic [1:0] sel, logic uns);
        logic [63:0] r;
        r = v & width_mask(sel);
        if (!uns) begin
            case (sel)
                W8:      r = {{56{v[7]}}, v[7:0]};
                W16:     r = {{48{v[15]}}, v[15:0]};
                W32:     r = {{32{v[31]}}, v[31:0]};
                default: r = v;
            endcase
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hdl/typed_integer_alu_core.sv
// Top level of the typed integer ALU: a fully pipelined datapath with a bit-per-stage divider.
//
// One operation per cycle is accepted while the pipeline is not full with a stalled output.
// Every operation runs the same path, so results leave in order. The pipeline depth is set
// by the radix-2 divider, one quotient bit per pipeline stage over 64 stages, behind a capture
// stage and a prepare stage (operand masking, simple ops, 32x32 partial products, divisor
// magnitudes), with one sign-fix stage at the end. Each stage holds its item while the stage
// after it is full and stalled, so bubbles collapse. A result waiting at the output stops
// input only once all 67 stages hold items.
// folded is low and the value zero for a zero divisor or an unused operation code.
`default_nettype none
module typed_integer_alu_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // mode[4:0], operand_a[68:5], operand_b[132:69], width_sel[134:133],
    // is_unsigned[135], target_width_sel[137:136], target_unsigned[138], zero[143:139]
    input  wire logic [143:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // value_out[63:0], folded[64], zero[71:65]
    output logic [71:0]       m_axis_tdata
);
    import tia_pkg::*;

    front_t front_reg;
    front_t front_next;
    pipe_t  stage_reg  [1:LAST_STAGE];
    pipe_t  stage_next [1:LAST_STAGE];
    logic   vld_reg    [0:LAST_STAGE];
    logic   adv        [0:LAST_STAGE];
    logic   out_ok;
    logic [63:0] out_val;

    // stall chain
    always_comb
    begin
        adv[LAST_STAGE] = !vld_reg[LAST_STAGE] || m_axis_tready;
        for (int i = LAST_STAGE - 1; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i + 1];
        end
    end

    assign s_axis_tready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (adv[0])
        begin
            vld_reg[0] <= s_axis_tvalid;
        end
    end

    for (genvar g = 1; g <= LAST_STAGE; g++)
    begin : g_vld
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else if (adv[g])
            begin
                vld_reg[g] <= vld_reg[g - 1];
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv[g] && vld_reg[g - 1])
            begin
                stage_reg[g] <= stage_next[g];
            end
        end
    end

    // capture: mask operands to width
    always_comb
    begin
        logic [63:0] m;
        front_next.mode  = s_axis_tdata[4:0];
        front_next.wsel  = s_axis_tdata[134:133];
        front_next.uns   = s_axis_tdata[135];
        front_next.twsel = s_axis_tdata[137:136];
        front_next.tuns  = s_axis_tdata[138];
        m = width_mask(s_axis_tdata[134:133]);
        front_next.a  = s_axis_tdata[68:5] & m;
        front_next.b  = s_axis_tdata[132:69] & m;
        front_next.sa = fit(s_axis_tdata[68:5], s_axis_tdata[134:133], 1'b0);
        front_next.sb = fit(s_axis_tdata[132:69], s_axis_tdata[134:133], 1'b0);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0] && s_axis_tvalid)
        begin
            front_reg <= front_next;
        end
    end

    // prepare: simple ops, partial products, divider magnitudes
    always_comb
    begin
        logic [5:0]  sh;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] v;
        logic        na;
        logic        nb;
        sh = front_reg.b[5:0] & (6'((8 << front_reg.wsel) - 1));
        x  = front_reg.uns ? front_reg.a : (front_reg.sa ^ 64'h8000_0000_0000_0000);
        y  = front_reg.uns ? front_reg.b : (front_reg.sb ^ 64'h8000_0000_0000_0000);
        na = front_reg.sa[63];
        nb = front_reg.sb[63];
        case (front_reg.mode)
            OP_ADD:  v = fit(front_reg.a + front_reg.b, front_reg.wsel, front_reg.uns);
            OP_SUB:  v = fit(front_reg.a - front_reg.b, front_reg.wsel, front_reg.uns);
            OP_AND:  v = fit(front_reg.a & front_reg.b, front_reg.wsel, front_reg.uns);
            OP_OR:   v = fit(front_reg.a | front_reg.b, front_reg.wsel, front_reg.uns);
            OP_XOR:  v = fit(front_reg.a ^ front_reg.b, front_reg.wsel, front_reg.uns);
            OP_SHL:  v = fit(front_reg.a << sh, front_reg.wsel, front_reg.uns);
            OP_SHR:  v = front_reg.uns ? (front_reg.a >> sh)
                                       : 64'($signed(front_reg.sa) >>> sh);
            OP_EQ:   v = {63'd0, x == y};
            OP_NE:   v = {63'd0, x != y};
            OP_LT:   v = {63'd0, x < y};
            OP_LE:   v = {63'd0, x <= y};
            OP_GT:   v = {63'd0, x > y};
            OP_GE:   v = {63'd0, x >= y};
            OP_CAST: v = fit(fit(front_reg.a, front_reg.wsel, front_reg.uns),
                             front_reg.twsel, front_reg.tuns);
            default: v = 64'd0;
        endcase
        stage_next[1].mode  = front_reg.mode;
        stage_next[1].wsel  = front_reg.wsel;
        stage_next[1].uns   = front_reg.uns;
        stage_next[1].val   = v;
        stage_next[1].p0    = 64'(front_reg.a[31:0]) * 64'(front_reg.b[31:0]);
        stage_next[1].p1    = 32'(front_reg.a[31:0] * front_reg.b[63:32]);
        stage_next[1].p2    = 32'(front_reg.a[63:32] * front_reg.b[31:0]);
        stage_next[1].neg_q = !front_reg.uns && (na != nb);
        stage_next[1].neg_r = !front_reg.uns && na;
        stage_next[1].dz    = (front_reg.b == 64'd0);
        stage_next[1].dvs   = (front_reg.uns || !nb) ? front_reg.sb & width_mask(2'(W64))
                                                    & (front_reg.uns ? front_reg.b : front_reg.sb)
                                                    : (64'd0 - front_reg.sb);
        stage_next[1].qr    = (front_reg.uns || !na) ? (front_reg.uns ? front_reg.a : front_reg.sa)
                                                    : (64'd0 - front_reg.sa);
        stage_next[1].rem   = 64'd0;
    end

    // divider steps; the first also sums the product
    for (genvar g = 2; g <= DIV_STEPS + 1; g++)
    begin : g_div
        always_comb
        begin
            logic [64:0] trial;
            stage_next[g] = stage_reg[g - 1];
            trial = {stage_reg[g - 1].rem, stage_reg[g - 1].qr[63]} - {1'b0, stage_reg[g - 1].dvs};
            if (!trial[64])
            begin
                stage_next[g].rem = trial[63:0];
                stage_next[g].qr  = {stage_reg[g - 1].qr[62:0], 1'b1};
            end
            else
            begin
                stage_next[g].rem = {stage_reg[g - 1].rem[62:0], stage_reg[g - 1].qr[63]};
                stage_next[g].qr  = {stage_reg[g - 1].qr[62:0], 1'b0};
            end
            if (g == 2 && stage_reg[g - 1].mode == OP_MUL)
            begin
                stage_next[g].val = fit(stage_reg[g - 1].p0
                                        + {stage_reg[g - 1].p1 + stage_reg[g - 1].p2, 32'd0},
                                        stage_reg[g - 1].wsel, stage_reg[g - 1].uns);
            end
        end
    end

    // final: sign fix of quotient or remainder, flag
    always_comb
    begin
        pipe_t       p;
        logic [63:0] r;
        logic        neg;
        p = stage_reg[LAST_STAGE - 1];
        stage_next[LAST_STAGE] = p;
        r   = (p.mode == OP_DIV) ? p.qr : p.rem;
        neg = (p.mode == OP_DIV) ? p.neg_q : p.neg_r;
        if (neg)
        begin
            r = 64'd0 - r;
        end
        if (p.mode == OP_DIV || p.mode == OP_MOD)
        begin
            stage_next[LAST_STAGE].val = p.dz ? 64'd0 : (p.uns ? r : fit(r, p.wsel, 1'b0));
            stage_next[LAST_STAGE].dz  = p.dz;
        end
        else
        begin
            stage_next[LAST_STAGE].dz = (p.mode > OP_CAST);
        end
    end

    assign out_val       = stage_reg[LAST_STAGE].val;
    assign out_ok        = !stage_reg[LAST_STAGE].dz;
    assign m_axis_tvalid = vld_reg[LAST_STAGE];
    assign m_axis_tdata  = {7'd0, out_ok, out_val};

    a_fold_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !out_ok |-> out_val == 64'd0)
        else $error("unfolded result carries a value");

    a_cmp_bool: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && stage_reg[LAST_STAGE].mode >= OP_EQ
        && stage_reg[LAST_STAGE].mode <= OP_GE |-> out_val[63:1] == 63'd0)
        else $error("comparison result not 0 or 1");

    a_sext8: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && stage_reg[LAST_STAGE].mode <= OP_SHR && !stage_reg[LAST_STAGE].uns
        && stage_reg[LAST_STAGE].wsel == W8
        |-> (out_val[63:7] == 57'd0 || out_val[63:7] == {57{1'b1}}))
        else $error("8-bit signed result not sign extended");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[LAST_STAGE] && !m_axis_tready |=> vld_reg[LAST_STAGE])
        else $error("pending result lost");

endmodule
`default_nettype wire
